// ===== sv/sasq_pkg.sv =====
// ----------------------------------------------------------------------------
// sasq_pkg
// shared types and constants of the stack and queue block
// ----------------------------------------------------------------------------
package sasq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_ENQUEUE = 3'd3,
        CMD_DEQUEUE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

endpackage

// ===== sv/shared_array_stack_queue.sv =====
// ----------------------------------------------------------------------------
// shared_array_stack_queue
// a stack and a fifo queue kept in one shared memory
// ----------------------------------------------------------------------------
// One RAM of DEPTH words holds a stack that grows down from the top entry and
// a queue that grows up from entry 0. Each input transfer carries a command in
// s_tuser and a word in s_tdata and gives exactly one result transfer with the
// word read (or 0 or all ones) in m_tdata and a status in m_tuser. The block
// takes one command per cycle while s_tready is high: every command makes at
// most one access to the single RAM port, at the cycle it is accepted, and its
// read data is registered in the RAM alongside the result stage, then passes
// through the output register to m_tdata. The result stage and the output
// register let commands keep flowing while one result waits. Dequeued slots
// are not reused until reset. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module shared_array_stack_queue
    import sasq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // data_in
    input  logic [CMD_W-1:0]    s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_tdata,   // data_out
    output logic [STATUS_W-1:0] m_tuser    // status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] stack_count_reg, stack_count_next;
    logic [CW-1:0] queue_written_reg, queue_written_next;
    logic [CW-1:0] queue_read_reg, queue_read_next;

    logic                  pend_valid_reg;
    logic                  pend_use_ram_reg;
    logic [DATA_WIDTH-1:0] pend_data_reg;
    status_t               pend_status_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_data_reg;
    status_t               out_status_reg;

    logic                  in_xfer;
    logic                  pend_move;
    logic                  store_full;
    logic                  ram_en;
    logic                  ram_we;
    logic [CW-1:0]         ram_addr_wide;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  use_ram;
    logic [DATA_WIDTH-1:0] const_data;
    status_t               status;
    logic [DATA_WIDTH-1:0] pend_word;

    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;
    assign in_xfer   = s_tvalid && s_tready;

    assign store_full = ({1'b0, stack_count_reg} + {1'b0, queue_written_reg})
                        >= (CW + 1)'(DEPTH);

    always_comb
    begin
        stack_count_next   = stack_count_reg;
        queue_written_next = queue_written_reg;
        queue_read_next    = queue_read_reg;
        ram_en             = 1'b0;
        ram_we             = 1'b0;
        ram_addr_wide      = '0;
        use_ram            = 1'b0;
        const_data         = '0;
        status             = ST_OK;
        unique case (cmd_t'(s_tuser)) inside
            CMD_PUSH:
            begin
                if (store_full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    stack_count_next = stack_count_reg + 1'b1;
                    ram_en           = 1'b1;
                    ram_we           = 1'b1;
                    ram_addr_wide    = CW'(DEPTH - 1) - stack_count_reg;
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (stack_count_reg == '0)
                begin
                    const_data = '1;
                    status     = ST_UNDERFLOW;
                end
                else
                begin
                    ram_en        = 1'b1;
                    use_ram       = 1'b1;
                    ram_addr_wide = CW'(DEPTH) - stack_count_reg;
                    if (cmd_t'(s_tuser) == CMD_POP)
                    begin
                        stack_count_next = stack_count_reg - 1'b1;
                    end
                end
            end
            CMD_ENQUEUE:
            begin
                if (store_full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    queue_written_next = queue_written_reg + 1'b1;
                    ram_en             = 1'b1;
                    ram_we             = 1'b1;
                    ram_addr_wide      = queue_written_reg;
                end
            end
            CMD_DEQUEUE:
            begin
                if (queue_read_reg >= queue_written_reg)
                begin
                    const_data = '1;
                    status     = ST_UNDERFLOW;
                end
                else
                begin
                    queue_read_next = queue_read_reg + 1'b1;
                    ram_en          = 1'b1;
                    use_ram         = 1'b1;
                    ram_addr_wide   = queue_read_reg;
                end
            end
            default:
            begin
                // unused codes change nothing and report ok
            end
        endcase
    end

    sasq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en && in_xfer),
        .we    (ram_we),
        .addr  (ram_addr_wide[AW-1:0]),
        .wdata (DATA_WIDTH'(s_tdata)),
        .rdata (ram_rdata)
    );

    assign pend_word = pend_use_ram_reg ? ram_rdata : pend_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg   <= '0;
            queue_written_reg <= '0;
            queue_read_reg    <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                stack_count_reg   <= stack_count_next;
                queue_written_reg <= queue_written_next;
                queue_read_reg    <= queue_read_next;
            end
            if (in_xfer)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_use_ram_reg <= use_ram;
            pend_data_reg    <= const_data;
            pend_status_reg  <= status;
        end
        if (pend_move)
        begin
            out_data_reg   <= WORD_W'(pend_word);
            out_status_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // stack entries plus queue entries never pass the memory size
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, stack_count_reg} + {1'b0, queue_written_reg}) <= (CW + 1)'(DEPTH))
    else $error("stack and queue regions overlap");

    // the queue never reads past what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_read_reg <= queue_written_reg)
    else $error("queue read pointer passed write pointer");

    // an underflow result carries all ones in the data width
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_UNDERFLOW) |-> m_tdata == WORD_W'({DATA_WIDTH{1'b1}}))
    else $error("underflow result without all-ones data");

    // the input stalls only while both result stages are held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pend_valid_reg && out_valid_reg && !m_tready)
    else $error("input stalled with room in the result path");

endmodule

// ===== sv/sasq_ram.sv =====
// ----------------------------------------------------------------------------
// sasq_ram
// single-port synchronous ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module sasq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                // read data only moves on a read, so it holds while a result waits
                rdata <= mem[addr];
            end
        end
    end

endmodule
